// File: hw/rtl/tscm_pkg.sv
// shared constants and types for the transport stream continuity monitor
`default_nettype none

package tscm_pkg;

  // header layout
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PID_W       = 13;
  localparam int unsigned PID_HI_W    = 5;
  localparam int unsigned CC_W        = 4;
  localparam int unsigned TOTAL_OUT_W = 32;

  localparam logic [BYTE_W-1:0] SYNC_VALUE = 8'h47;

  localparam int unsigned TEI_BIT  = 7;
  localparam int unsigned AF_BIT   = 5;
  localparam int unsigned DISC_BIT = 7;

  // parameter defaults
  localparam int unsigned PID_COUNT_DEFAULT   = 8192;
  localparam int unsigned COUNT_WIDTH_DEFAULT = 32;

  // one entry of the per-pid table: seen flag and last continuity counter
  typedef struct packed {
    logic            seen;
    logic [CC_W-1:0] cc;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// File: hw/rtl/tscm_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module tscm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ts_continuity_monitor.sv
// top level of the transport stream continuity monitor
//
// Checks the continuity counter of each transport packet header against the
// last counter seen on the same PID and keeps four saturating totals: tracked
// packets, continuity errors, estimated lost packets and transport errors.
// One header word is taken per cycle while pkt_stall is low; its result word
// (the totals after that packet) is registered as the word leaves stage one. The
// per-PID table lives in a single RAM that is read when a word is accepted
// and written when it leaves stage one; a one-entry bypass covers
// back-to-back packets on the same PID. After reset the table is cleared one
// entry per cycle over all PID_COUNT entries (8192 by default), and pkt_stall
// stays high until that pass is done. PIDs are folded as PID modulo PID_COUNT.
`default_nettype none

module ts_continuity_monitor #(
  parameter int unsigned PID_COUNT   = tscm_pkg::PID_COUNT_DEFAULT,
  parameter int unsigned COUNT_WIDTH = tscm_pkg::COUNT_WIDTH_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // packet header channel
  input  wire logic                             pkt_valid,
  output      logic                             pkt_stall,
  input  wire logic [tscm_pkg::BYTE_W-1:0]      sync_byte,
  input  wire logic [tscm_pkg::BYTE_W-1:0]      header_byte1,
  input  wire logic [tscm_pkg::BYTE_W-1:0]      header_byte2,
  input  wire logic [tscm_pkg::BYTE_W-1:0]      header_byte3,
  input  wire logic [tscm_pkg::BYTE_W-1:0]      adapt_length,
  input  wire logic [tscm_pkg::BYTE_W-1:0]      adapt_flags,
  // totals channel
  output      logic                             res_valid,
  input  wire logic                             res_stall,
  output      logic [tscm_pkg::TOTAL_OUT_W-1:0] tracked_count,
  output      logic [tscm_pkg::TOTAL_OUT_W-1:0] continuity_errors,
  output      logic [tscm_pkg::TOTAL_OUT_W-1:0] lost_estimate,
  output      logic [tscm_pkg::TOTAL_OUT_W-1:0] transport_error_count
);

  localparam int unsigned IDX_W = $clog2(PID_COUNT);
  localparam int unsigned PID_W = tscm_pkg::PID_W;
  localparam int unsigned CC_W  = tscm_pkg::CC_W;
  localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(PID_COUNT - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // pid modulo table size by constant shifted subtracts
  function automatic logic [PID_W-1:0] pid_to_index(input logic [PID_W-1:0] pid);
    logic [PID_W-1:0] r;
    r = pid;
    for (int k = PID_W - 1; k >= 0; k--) begin
      if ((PID_COUNT << k) < (1 << PID_W)) begin
        if (r >= PID_W'(PID_COUNT << k)) begin
          r = r - PID_W'(PID_COUNT << k);
        end
      end
    end
    return r;
  endfunction

  // saturating increment
  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] acc);
    return (acc == COUNT_MAX) ? acc : acc + COUNT_WIDTH'(1);
  endfunction

  // saturating add of a counter gap
  function automatic logic [COUNT_WIDTH-1:0] sat_add_gap(
    input logic [COUNT_WIDTH-1:0] acc,
    input logic [CC_W-1:0]        gap
  );
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, acc} + (COUNT_WIDTH + 1)'(gap);
    return sum[COUNT_WIDTH] ? COUNT_MAX : sum[COUNT_WIDTH-1:0];
  endfunction

  // table clearing pass
  logic             clearing;
  logic [IDX_W-1:0] clear_addr;

  // handshake
  logic pkt_accept;
  logic s1_valid;
  logic s1_advance;

  // decoded header fields of the incoming word
  logic             in_sync_ok;
  logic             in_tei;
  logic             in_disc;
  logic [IDX_W-1:0] in_idx;
  logic [CC_W-1:0]  in_cc;

  // first stage registers
  logic             s1_sync_ok;
  logic             s1_tei;
  logic             s1_disc;
  logic [IDX_W-1:0] s1_idx;
  logic [CC_W-1:0]  s1_cc;

  // bypass of the write made at the edge the stage-one word was read
  logic             byp_valid;
  logic [IDX_W-1:0] byp_idx;
  tscm_pkg::entry_t byp_data;

  // table port signals
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  tscm_pkg::entry_t ram_wdata;
  tscm_pkg::entry_t ram_rdata;
  logic             item_we;
  tscm_pkg::entry_t item_entry;

  // continuity check
  tscm_pkg::entry_t s1_entry;
  logic [CC_W-1:0]  expected_cc;
  logic [CC_W-1:0]  gap;
  logic             mismatch;

  // totals
  logic [COUNT_WIDTH-1:0] tracked_total;
  logic [COUNT_WIDTH-1:0] mismatch_total;
  logic [COUNT_WIDTH-1:0] lost_total;
  logic [COUNT_WIDTH-1:0] tei_total;

  // handshake control
  assign s1_advance = !res_valid || !res_stall;
  assign pkt_stall  = clearing || (s1_valid && !s1_advance);
  assign pkt_accept = pkt_valid && !pkt_stall;

  // header decode
  assign in_sync_ok = (sync_byte == tscm_pkg::SYNC_VALUE);
  assign in_tei     = header_byte1[tscm_pkg::TEI_BIT];
  assign in_disc    = header_byte3[tscm_pkg::AF_BIT] && (adapt_length != '0)
                      && adapt_flags[tscm_pkg::DISC_BIT];
  assign in_idx     = IDX_W'(pid_to_index({header_byte1[tscm_pkg::PID_HI_W-1:0],
                                           header_byte2}));
  assign in_cc      = header_byte3[CC_W-1:0];

  // clear sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + IDX_W'(1);
      if (clear_addr == LAST_IDX) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage valid and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      res_valid <= 1'b0;
      byp_valid <= 1'b0;
    end else begin
      if (pkt_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_valid && s1_advance) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (pkt_accept) begin
        byp_valid <= item_we;
      end
    end
  end

  // stage-one payload and bypass capture
  always_ff @(posedge clk) begin
    if (pkt_accept) begin
      s1_sync_ok <= in_sync_ok;
      s1_tei     <= in_tei;
      s1_disc    <= in_disc;
      s1_idx     <= in_idx;
      s1_cc      <= in_cc;
      byp_idx    <= s1_idx;
      byp_data   <= item_entry;
    end
  end

  // table entry for the word in stage one
  assign s1_entry    = (byp_valid && (byp_idx == s1_idx)) ? byp_data : ram_rdata;
  assign expected_cc = s1_entry.cc + CC_W'(1);
  assign gap         = s1_cc - expected_cc;
  assign mismatch    = !s1_disc && s1_entry.seen && (s1_cc != expected_cc);

  // table write: clear sweep or update from stage one
  assign item_we         = s1_valid && s1_advance && s1_sync_ok;
  assign item_entry.seen = 1'b1;
  assign item_entry.cc   = s1_cc;

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = item_we;
      ram_waddr = s1_idx;
      ram_wdata = item_entry;
    end
  end

  tscm_ram #(
    .WIDTH (tscm_pkg::ENTRY_W),
    .DEPTH (PID_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (pkt_accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // totals update as a synced word moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_total  <= '0;
      mismatch_total <= '0;
      lost_total     <= '0;
      tei_total      <= '0;
    end else if (item_we) begin
      tracked_total <= sat_inc(tracked_total);
      if (s1_tei) begin
        tei_total <= sat_inc(tei_total);
      end
      if (mismatch) begin
        mismatch_total <= sat_inc(mismatch_total);
        lost_total     <= sat_add_gap(lost_total, gap);
      end
    end
  end

  // result word: totals only change when the next word takes the register
  assign tracked_count         = tscm_pkg::TOTAL_OUT_W'(tracked_total);
  assign continuity_errors     = tscm_pkg::TOTAL_OUT_W'(mismatch_total);
  assign lost_estimate         = tscm_pkg::TOTAL_OUT_W'(lost_total);
  assign transport_error_count = tscm_pkg::TOTAL_OUT_W'(tei_total);

endmodule

`default_nettype wire

// File: tb/sv/tscm_checker.sv
// checker for the transport stream continuity monitor: predicts totals and compares result words
`timescale 1ns / 100ps

module tscm_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pkt_valid,
  input  logic                             pkt_stall,
  input  logic [tscm_pkg::BYTE_W-1:0]      sync_byte,
  input  logic [tscm_pkg::BYTE_W-1:0]      header_byte1,
  input  logic [tscm_pkg::BYTE_W-1:0]      header_byte2,
  input  logic [tscm_pkg::BYTE_W-1:0]      header_byte3,
  input  logic [tscm_pkg::BYTE_W-1:0]      adapt_length,
  input  logic [tscm_pkg::BYTE_W-1:0]      adapt_flags,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  logic [tscm_pkg::TOTAL_OUT_W-1:0] tracked_count,
  input  logic [tscm_pkg::TOTAL_OUT_W-1:0] continuity_errors,
  input  logic [tscm_pkg::TOTAL_OUT_W-1:0] lost_estimate,
  input  logic [tscm_pkg::TOTAL_OUT_W-1:0] transport_error_count,
  output int unsigned                      mismatches,
  output int unsigned                      outstanding
);

  localparam int unsigned TABLE_DEPTH = tscm_pkg::PID_COUNT_DEFAULT;
  localparam int unsigned BYTE_W      = tscm_pkg::BYTE_W;
  localparam int unsigned PID_W       = tscm_pkg::PID_W;
  localparam int unsigned CC_W        = tscm_pkg::CC_W;
  localparam int unsigned TOTAL_OUT_W = tscm_pkg::TOTAL_OUT_W;

  typedef logic [TOTAL_OUT_W-1:0] total_t;

  typedef struct packed {
    total_t tracked;
    total_t errors;
    total_t lost;
    total_t tei;
  } totals_t;

  // shadow of the per-pid table and the running totals
  logic            pid_seen_tab [TABLE_DEPTH];
  logic [CC_W-1:0] last_cc_tab  [TABLE_DEPTH];
  totals_t         run_totals;

  // totals still owed by the block, oldest first
  totals_t         owed_totals [$];

  initial begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      pid_seen_tab[i] = 1'b0;
      last_cc_tab[i]  = '0;
    end
    run_totals  = '0;
    mismatches  = 0;
    outstanding = 0;
  end

  // saturating add, totals stop at all ones
  function automatic total_t sat_add(input total_t acc, input logic [CC_W-1:0] amount);
    logic [TOTAL_OUT_W:0] sum;
    sum = {1'b0, acc} + (TOTAL_OUT_W + 1)'(amount);
    return sum[TOTAL_OUT_W] ? '1 : sum[TOTAL_OUT_W-1:0];
  endfunction

  // advance the shadow state by one header and return the totals after it
  function automatic totals_t predict_totals(
    input logic [BYTE_W-1:0] b0,
    input logic [BYTE_W-1:0] b1,
    input logic [BYTE_W-1:0] b2,
    input logic [BYTE_W-1:0] b3,
    input logic [BYTE_W-1:0] alen,
    input logic [BYTE_W-1:0] aflags
  );
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    logic [CC_W-1:0]  next_cc;
    logic             reload;
    int unsigned      idx;
    if (b0 == tscm_pkg::SYNC_VALUE) begin
      pid    = {b1[tscm_pkg::PID_HI_W-1:0], b2};
      idx    = pid % TABLE_DEPTH;
      cc     = b3[CC_W-1:0];
      reload = b3[tscm_pkg::AF_BIT] && (alen != '0) && aflags[tscm_pkg::DISC_BIT];
      if (b1[tscm_pkg::TEI_BIT])
        run_totals.tei = sat_add(run_totals.tei, CC_W'(1));
      // continuity check only on a pid with history and no discontinuity
      if (!reload && pid_seen_tab[idx]) begin
        next_cc = last_cc_tab[idx] + 1'b1;
        if (cc != next_cc) begin
          run_totals.errors = sat_add(run_totals.errors, CC_W'(1));
          run_totals.lost   = sat_add(run_totals.lost, cc - next_cc);
        end
      end
      last_cc_tab[idx]   = cc;
      pid_seen_tab[idx]  = 1'b1;
      run_totals.tracked = sat_add(run_totals.tracked, CC_W'(1));
    end
    return run_totals;
  endfunction

  task automatic report_mismatch(input string what, input total_t got, input total_t want);
    $display("%0t: %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // compare result words first, then record the header word of the same edge
  always @(posedge clk) begin : watch
    totals_t want;
    if (!rst) begin
      if (res_valid && !res_stall) begin
        if (owed_totals.size() == 0) begin
          report_mismatch("result word with nothing pending, tracked_count", tracked_count, '0);
        end else begin
          want = owed_totals.pop_front();
          if (tracked_count !== want.tracked)
            report_mismatch("tracked_count", tracked_count, want.tracked);
          if (continuity_errors !== want.errors)
            report_mismatch("continuity_errors", continuity_errors, want.errors);
          if (lost_estimate !== want.lost)
            report_mismatch("lost_estimate", lost_estimate, want.lost);
          if (transport_error_count !== want.tei)
            report_mismatch("transport_error_count", transport_error_count, want.tei);
        end
      end
      if (pkt_valid && !pkt_stall)
        owed_totals.push_back(predict_totals(sync_byte, header_byte1, header_byte2,
                                             header_byte3, adapt_length, adapt_flags));
      outstanding <= owed_totals.size();
    end
  end

endmodule

// File: tb/sv/tb_ts_continuity_monitor.sv
// testbench top for the transport stream continuity monitor: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb_ts_continuity_monitor;

  localparam int unsigned RANDOM_WORDS = 1450;
  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned POOL_SIZE    = 12;
  localparam int unsigned BYTE_W       = tscm_pkg::BYTE_W;
  localparam int unsigned PID_W        = tscm_pkg::PID_W;
  localparam int unsigned CC_W         = tscm_pkg::CC_W;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             pkt_valid    = 1'b0;
  logic                             pkt_stall;
  logic [BYTE_W-1:0]                sync_byte    = '0;
  logic [BYTE_W-1:0]                header_byte1 = '0;
  logic [BYTE_W-1:0]                header_byte2 = '0;
  logic [BYTE_W-1:0]                header_byte3 = '0;
  logic [BYTE_W-1:0]                adapt_length = '0;
  logic [BYTE_W-1:0]                adapt_flags  = '0;
  logic                             res_valid;
  logic                             res_stall    = 1'b0;
  logic [tscm_pkg::TOTAL_OUT_W-1:0] tracked_count;
  logic [tscm_pkg::TOTAL_OUT_W-1:0] continuity_errors;
  logic [tscm_pkg::TOTAL_OUT_W-1:0] lost_estimate;
  logic [tscm_pkg::TOTAL_OUT_W-1:0] transport_error_count;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned cycle_count = 0;

  // idling controls
  logic        gaps_on    = 1'b0;
  logic        stall_on   = 1'b0;
  int unsigned stall_left = 0;

  always #5 clk = ~clk;

  ts_continuity_monitor u_top (
    .clk                   (clk),
    .rst                   (rst),
    .pkt_valid             (pkt_valid),
    .pkt_stall             (pkt_stall),
    .sync_byte             (sync_byte),
    .header_byte1          (header_byte1),
    .header_byte2          (header_byte2),
    .header_byte3          (header_byte3),
    .adapt_length          (adapt_length),
    .adapt_flags           (adapt_flags),
    .res_valid             (res_valid),
    .res_stall             (res_stall),
    .tracked_count         (tracked_count),
    .continuity_errors     (continuity_errors),
    .lost_estimate         (lost_estimate),
    .transport_error_count (transport_error_count)
  );

  tscm_checker u_checker (
    .clk                   (clk),
    .rst                   (rst),
    .pkt_valid             (pkt_valid),
    .pkt_stall             (pkt_stall),
    .sync_byte             (sync_byte),
    .header_byte1          (header_byte1),
    .header_byte2          (header_byte2),
    .header_byte3          (header_byte3),
    .adapt_length          (adapt_length),
    .adapt_flags           (adapt_flags),
    .res_valid             (res_valid),
    .res_stall             (res_stall),
    .tracked_count         (tracked_count),
    .continuity_errors     (continuity_errors),
    .lost_estimate         (lost_estimate),
    .transport_error_count (transport_error_count),
    .mismatches            (mismatches),
    .outstanding           (outstanding)
  );

  // idle length: mostly short, now and then long
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res_stall  <= 1'b1;
    end else if (stall_on && $urandom_range(0, 2) == 0) begin
      stall_left <= gap_len() - 1;
      res_stall  <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  // present one header word, hold it until taken, then maybe idle
  task automatic send_word(
    input logic [BYTE_W-1:0] b0,
    input logic [BYTE_W-1:0] b1,
    input logic [BYTE_W-1:0] b2,
    input logic [BYTE_W-1:0] b3,
    input logic [BYTE_W-1:0] alen,
    input logic [BYTE_W-1:0] aflags
  );
    int unsigned idle;
    sync_byte    <= b0;
    header_byte1 <= b1;
    header_byte2 <= b2;
    header_byte3 <= b3;
    adapt_length <= alen;
    adapt_flags  <= aflags;
    pkt_valid    <= 1'b1;
    do @(posedge clk); while (pkt_stall);
    idle = (gaps_on && $urandom_range(0, 1) == 0) ? gap_len() : 0;
    if (idle != 0) begin
      pkt_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  // well-synced packet header, unused bits filled at random
  task automatic send_packet(
    input logic [PID_W-1:0]  pid,
    input logic [CC_W-1:0]   cc,
    input logic              tei,
    input logic              af,
    input logic [BYTE_W-1:0] alen,
    input logic [BYTE_W-1:0] aflags
  );
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b3;
    b1 = BYTE_W'($urandom_range(0, 255));
    b3 = BYTE_W'($urandom_range(0, 255));
    b1[tscm_pkg::TEI_BIT]        = tei;
    b1[tscm_pkg::PID_HI_W-1:0]   = pid[PID_W-1:BYTE_W];
    b3[tscm_pkg::AF_BIT]         = af;
    b3[CC_W-1:0]                 = cc;
    send_word(tscm_pkg::SYNC_VALUE, b1, pid[BYTE_W-1:0], b3, alen, aflags);
  endtask

  // stop sending until every owed result word has come back
  task automatic drain_results();
    pkt_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_ts_continuity_monitor: FAIL");
    $finish;
  end

  initial begin
    logic [PID_W-1:0] pid_pool [POOL_SIZE];
    logic [CC_W-1:0]  pool_cc  [POOL_SIZE];
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    int unsigned      k;
    int unsigned      pick;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: bad sync bytes, extremes, wraps, discontinuity corners
    send_word(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(tscm_pkg::SYNC_VALUE - 8'd1, 8'h80, 8'h10, 8'h00, 8'h00, 8'h00);
    send_word(tscm_pkg::SYNC_VALUE + 8'd1, 8'h80, 8'h10, 8'h00, 8'h00, 8'h00);
    send_packet(13'h0000, 4'd0, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h0000, 4'd1, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h0000, 4'd2, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h0000, 4'd4, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h0000, 4'd4, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h1FFF, 4'd15, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h1FFF, 4'd0, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h1FFF, 4'd7, 1'b0, 1'b1, 8'd1, 8'h80);
    send_packet(13'h1FFF, 4'd3, 1'b0, 1'b1, 8'd0, 8'h80);
    send_packet(13'h1FFF, 4'd9, 1'b0, 1'b0, 8'hFF, 8'hFF);
    send_packet(13'h1FFF, 4'd0, 1'b0, 1'b1, 8'hFF, 8'h7F);
    send_packet(13'h0000, 4'd0, 1'b1, 1'b0, 8'd0, 8'h00);
    send_word(tscm_pkg::SYNC_VALUE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(tscm_pkg::SYNC_VALUE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_packet(13'h0100, 4'd9, 1'b1, 1'b1, 8'd183, 8'hC0);
    send_packet(13'h0100, 4'd10, 1'b0, 1'b0, 8'd0, 8'h00);
    send_packet(13'h0100, 4'd10, 1'b1, 1'b0, 8'd0, 8'h00);
    drain_results();

    // pid pool so that most random packets continue a stream
    for (int i = 0; i < POOL_SIZE; i++) begin
      pid_pool[i] = PID_W'($urandom_range(0, 2**PID_W - 1));
      pool_cc[i]  = CC_W'($urandom_range(0, 2**CC_W - 1));
    end
    pid_pool[0] = '0;
    pid_pool[1] = '1;

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // rotate through idling mixes, including a stretch with none
      case ((n / 150) % 4)
        0: begin gaps_on = 1'b1; stall_on = 1'b1; end
        1: begin gaps_on = 1'b0; stall_on = 1'b0; end
        2: begin gaps_on = 1'b1; stall_on = 1'b0; end
        default: begin gaps_on = 1'b0; stall_on = 1'b1; end
      endcase
      if (n == RANDOM_WORDS / 2)
        drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise word, sync almost always wrong
        send_word(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                  BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
      end else begin
        k  = $urandom_range(0, POOL_SIZE - 1);
        cc = ($urandom_range(0, 6) == 0) ? CC_W'($urandom_range(0, 2**CC_W - 1))
                                         : pool_cc[k] + 1'b1;
        if ($urandom_range(0, 4) == 0) begin
          pid = PID_W'($urandom_range(0, 2**PID_W - 1));
        end else begin
          pid        = pid_pool[k];
          pool_cc[k] = cc;
        end
        send_packet(pid, cc, $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)),
                    ($urandom_range(0, 2) == 0) ? '0 : BYTE_W'($urandom_range(0, 255)),
                    {$urandom_range(0, 4) == 0, 7'($urandom_range(0, 127))});
      end
    end

    // wait out the last result words, then a short tail
    stall_on = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_ts_continuity_monitor: PASS");
    end else begin
      $display("tb_ts_continuity_monitor: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/tscm_pkg.sv
hw/rtl/tscm_ram.sv
hw/rtl/ts_continuity_monitor.sv
tb/sv/tscm_checker.sv
tb/sv/tb_ts_continuity_monitor.sv
